// ===== rtl/vector_angle_degrees_unit_defines.svh =====
// assertion macros for the vector angle unit
`ifndef VECTOR_ANGLE_DEGREES_UNIT_DEFINES_SVH
`define VECTOR_ANGLE_DEGREES_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define VAD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vad assertion failed");
// next-cycle implication
`define VAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vad assertion failed");
`else
`define VAD_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define VAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/vad_pkg.sv =====
`timescale 1ns / 1ps
package vad_pkg;

    localparam int DEF_MAX_DIM  = 8;
    localparam int CORDIC_ITERS = 23;
    localparam int ITER_W       = 5;
    localparam int Z_W          = 25;
    localparam int ATAN_W       = 22;
    localparam logic [15:0] ANGLE_180 = 16'd46080;
    localparam logic [Z_W-1:0] Z_MAX  = 25'd5898240;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCALE,
        S_MUL_P,
        S_MUL_Q,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_NORM,
        S_CORDIC_GO,
        S_CORDIC_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;

    // atan(2^-i) in degrees, scaled by 65536
    function automatic logic [ATAN_W-1:0] atan_tab(input logic [ITER_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/vad_accum.sv =====
`timescale 1ns / 1ps
module vad_accum #(
    parameter int MAX_DIM = vad_pkg::DEF_MAX_DIM,
    parameter int DOT_W   = 32 + $clog2(MAX_DIM),
    parameter int NRM_W   = 31 + $clog2(MAX_DIM)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_beat,
    input  logic signed [15:0]      i_a,
    input  logic signed [15:0]      i_b,
    input  logic                    i_clear,
    output logic signed [DOT_W-1:0] o_dot,
    output logic [NRM_W-1:0]        o_norm_a,
    output logic [NRM_W-1:0]        o_norm_b
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic signed [DOT_W-1:0] r_dot;
    logic [NRM_W-1:0]        r_na;
    logic [NRM_W-1:0]        r_nb;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [31:0]      prod_ab;
    logic signed [31:0]      prod_aa;
    logic signed [31:0]      prod_bb;

    // element products
    assign prod_ab = i_a * i_b;
    assign prod_aa = i_a * i_a;
    assign prod_bb = i_b * i_b;

    // accumulate up to MAX_DIM pairs, ignore the rest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
        end else if (i_beat && (r_cnt < CNT_W'(MAX_DIM))) begin
            r_dot <= r_dot + DOT_W'(prod_ab);
            r_na  <= r_na + NRM_W'(unsigned'(prod_aa));
            r_nb  <= r_nb + NRM_W'(unsigned'(prod_bb));
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_dot    = r_dot;
    assign o_norm_a = r_na;
    assign o_norm_b = r_nb;

endmodule

// ===== rtl/vad_isqrt.sv =====
`timescale 1ns / 1ps
module vad_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vad_pkg::t_unit_ctl  i_ctl,
    input  logic [61:0]         i_value,
    output vad_pkg::t_unit_ctl  o_ctl,
    output logic [31:0]         o_root
);

    logic        r_busy;
    logic        r_done;
    logic [62:0] r_v;
    logic [62:0] r_res;
    logic [62:0] r_one;
    logic [62:0] trial;

    // one result bit per cycle, 32 steps
    assign trial = r_res + r_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_one[1:0] != 2'b00)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v   <= {1'b0, i_value};
            r_res <= '0;
            r_one <= 63'(1) << 62;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
        end
    end

    assign o_ctl.start = r_busy;
    assign o_ctl.done  = r_done;
    assign o_root      = r_res[31:0];

endmodule

// ===== rtl/vad_cordic.sv =====
`timescale 1ns / 1ps
module vad_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vad_pkg::t_unit_ctl              i_ctl,
    input  logic [31:0]                     i_x,
    input  logic [31:0]                     i_y,
    output vad_pkg::t_unit_ctl              o_ctl,
    output logic signed [vad_pkg::Z_W-1:0]  o_z
);

    logic                              r_busy;
    logic                              r_done;
    logic [vad_pkg::ITER_W-1:0]        r_i;
    logic signed [33:0]                r_x;
    logic signed [33:0]                r_y;
    logic signed [vad_pkg::Z_W-1:0]    r_z;
    logic signed [33:0]                sx;
    logic signed [33:0]                sy;
    logic signed [vad_pkg::Z_W-1:0]    ang;

    // shared shifter, floor shifts
    assign sx  = r_x >>> r_i;
    assign sy  = r_y >>> r_i;
    assign ang = $signed({3'b000, vad_pkg::atan_tab(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_i == vad_pkg::ITER_W'(vad_pkg::CORDIC_ITERS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one vectoring rotation per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= $signed({2'b00, i_x});
            r_y <= $signed({2'b00, i_y});
            r_z <= '0;
            r_i <= '0;
        end else if (r_busy) begin
            if (!r_y[33]) begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + ang;
            end else begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - ang;
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_ctl.start = r_busy;
    assign o_ctl.done  = r_done;
    assign o_z         = r_z;

endmodule

// ===== rtl/vector_angle_degrees_unit.sv =====
`timescale 1ns / 1ps
// Angle between two vectors in degrees. Element pairs stream in one beat per
// cycle and each is added into registered accumulators; pairs beyond MAX_DIM
// in a vector are ignored. The beat marked tlast closes the vector: the unit
// then stops taking beats until its result is loaded into the output register,
// which waits for any previous result to be taken, while one sequencer runs
// norm scaling, two passes through one shared 31x31 multiplier, a square root,
// normalization and 23 CORDIC rotations. The result (unsigned Q8.8 degrees, 0
// to 180, plus a zero-length flag) is held in the output register, so the next
// vector may start streaming while it waits to be taken. A zero-norm vector
// gives angle 0 with the flag set.
`include "vector_angle_degrees_unit_defines.svh"
module vector_angle_degrees_unit #(
    parameter int MAX_DIM = vad_pkg::DEF_MAX_DIM
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // a_elem[15:0], b_elem[31:16]
    input  logic        i_s_axis_tlast,   // last_elem
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // angle_deg[15:0]
    output logic        o_m_axis_tuser    // zero_length
);

    localparam int DOT_W = 32 + $clog2(MAX_DIM);
    localparam int NRM_W = 31 + $clog2(MAX_DIM);

    vad_pkg::t_state r_state;
    vad_pkg::t_state n_state;

    logic                         in_beat;
    logic                         acc_clear;
    logic signed [DOT_W-1:0]      acc_dot;
    logic [NRM_W-1:0]             acc_na;
    logic [NRM_W-1:0]             acc_nb;

    logic [NRM_W-1:0]             r_na;
    logic [NRM_W-1:0]             r_nb;
    logic [DOT_W-1:0]             r_mag;
    logic                         r_neg;
    logic [61:0]                  r_p;
    logic [62:0]                  r_q2;
    logic [31:0]                  r_x;
    logic [31:0]                  r_y;
    logic [15:0]                  r_angle;
    logic                         r_zl;
    logic                         r_out_valid;
    logic [15:0]                  r_out_angle;
    logic                         r_out_zl;

    logic                         big_a;
    logic                         big_b;
    logic [1:0]                   mag_sh;
    logic [30:0]                  mul_a;
    logic [30:0]                  mul_b;
    logic [61:0]                  prod;
    logic [61:0]                  sq_in;
    logic                         out_free;
    logic                         small_xy;

    vad_pkg::t_unit_ctl           sq_req;
    vad_pkg::t_unit_ctl           sq_rsp;
    logic [31:0]                  sq_root;
    vad_pkg::t_unit_ctl           cd_req;
    vad_pkg::t_unit_ctl           cd_rsp;
    logic signed [vad_pkg::Z_W-1:0] cd_z;
    logic [vad_pkg::Z_W-1:0]      z_clamp;
    logic [vad_pkg::Z_W-1:0]      z_round;
    logic [15:0]                  q_angle;

    assign o_s_axis_tready = (r_state == vad_pkg::S_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign acc_clear       = (r_state == vad_pkg::S_CHECK);
    assign out_free        = !r_out_valid || i_m_axis_tready;

    vad_accum #(
        .MAX_DIM (MAX_DIM),
        .DOT_W   (DOT_W),
        .NRM_W   (NRM_W)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (in_beat),
        .i_a      (i_s_axis_tdata[15:0]),
        .i_b      (i_s_axis_tdata[31:16]),
        .i_clear  (acc_clear),
        .o_dot    (acc_dot),
        .o_norm_a (acc_na),
        .o_norm_b (acc_nb)
    );

    // norm scaling tests
    assign big_a  = (r_na[NRM_W-1:31] != '0);
    assign big_b  = (r_nb[NRM_W-1:31] != '0);
    assign mag_sh = 2'(big_a) + 2'(big_b);

    // shared multiplier
    assign mul_a = (r_state == vad_pkg::S_MUL_P) ? r_na[30:0] : r_mag[30:0];
    assign mul_b = (r_state == vad_pkg::S_MUL_P) ? r_nb[30:0] : r_mag[30:0];
    assign prod  = mul_a * mul_b;

    // radicand: cross term squared, zero when the ratio reaches one
    assign sq_in = ({1'b0, r_p} > r_q2) ? 62'({1'b0, r_p} - r_q2) : '0;

    assign sq_req.start = (r_state == vad_pkg::S_SQRT_GO);
    assign sq_req.done  = 1'b0;

    vad_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq_req),
        .i_value (sq_in),
        .o_ctl   (sq_rsp),
        .o_root  (sq_root)
    );

    assign small_xy = (r_x[31:30] == 2'b00) && (r_y[31:30] == 2'b00);

    assign cd_req.start = (r_state == vad_pkg::S_CORDIC_GO);
    assign cd_req.done  = 1'b0;

    vad_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cd_req),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_ctl   (cd_rsp),
        .o_z     (cd_z)
    );

    // clamp to a quarter turn and round to q8.8
    always_comb begin
        if (cd_z < 0) begin
            z_clamp = '0;
        end else if (unsigned'(cd_z) > vad_pkg::Z_MAX) begin
            z_clamp = vad_pkg::Z_MAX;
        end else begin
            z_clamp = unsigned'(cd_z);
        end
        z_round = z_clamp + vad_pkg::Z_W'(128);
        q_angle = r_neg ? (vad_pkg::ANGLE_180 - z_round[23:8]) : z_round[23:8];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vad_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vad_pkg::S_IDLE: begin
                if (in_beat && i_s_axis_tlast) n_state = vad_pkg::S_CHECK;
            end
            vad_pkg::S_CHECK: begin
                if ((acc_na == '0) || (acc_nb == '0)) n_state = vad_pkg::S_DONE;
                else n_state = vad_pkg::S_SCALE;
            end
            vad_pkg::S_SCALE: begin
                if (!big_a && !big_b) n_state = vad_pkg::S_MUL_P;
            end
            vad_pkg::S_MUL_P:   n_state = vad_pkg::S_MUL_Q;
            vad_pkg::S_MUL_Q:   n_state = vad_pkg::S_SQRT_GO;
            vad_pkg::S_SQRT_GO: n_state = vad_pkg::S_SQRT_WAIT;
            vad_pkg::S_SQRT_WAIT: begin
                if (sq_rsp.done) begin
                    if ((r_mag == '0) && (sq_root == '0)) n_state = vad_pkg::S_DONE;
                    else n_state = vad_pkg::S_NORM;
                end
            end
            vad_pkg::S_NORM: begin
                if (!small_xy) n_state = vad_pkg::S_CORDIC_GO;
            end
            vad_pkg::S_CORDIC_GO: n_state = vad_pkg::S_CORDIC_WAIT;
            vad_pkg::S_CORDIC_WAIT: begin
                if (cd_rsp.done) n_state = vad_pkg::S_DONE;
            end
            vad_pkg::S_DONE: begin
                if (out_free) n_state = vad_pkg::S_IDLE;
            end
            default: n_state = vad_pkg::S_IDLE;
        endcase
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            vad_pkg::S_CHECK: begin
                r_na    <= acc_na;
                r_nb    <= acc_nb;
                r_mag   <= acc_dot[DOT_W-1] ? unsigned'(-acc_dot) : unsigned'(acc_dot);
                r_neg   <= acc_dot[DOT_W-1];
                r_angle <= '0;
                r_zl    <= (acc_na == '0) || (acc_nb == '0);
            end
            vad_pkg::S_SCALE: begin
                if (big_a) r_na <= r_na >> 2;
                if (big_b) r_nb <= r_nb >> 2;
                r_mag <= r_mag >> mag_sh;
            end
            vad_pkg::S_MUL_P: begin
                r_p <= prod;
            end
            vad_pkg::S_MUL_Q: begin
                if (r_mag[DOT_W-1:31] != '0) r_q2 <= {1'b0, r_p} + 63'(1);
                else r_q2 <= {1'b0, prod};
            end
            vad_pkg::S_SQRT_WAIT: begin
                r_x <= r_mag[31:0];
                r_y <= sq_root;
            end
            vad_pkg::S_NORM: begin
                if (small_xy) begin
                    r_x <= r_x << 1;
                    r_y <= r_y << 1;
                end
            end
            vad_pkg::S_CORDIC_WAIT: begin
                if (cd_rsp.done) r_angle <= q_angle;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == vad_pkg::S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == vad_pkg::S_DONE) && out_free) begin
            r_out_angle <= r_angle;
            r_out_zl    <= r_zl;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_angle;
    assign o_m_axis_tuser  = r_out_zl;

    // checks
    `VAD_ASSERT_NOW(a_cordic_done_wait, i_clk, i_rst_n, cd_rsp.done, r_state == vad_pkg::S_CORDIC_WAIT)
    `VAD_ASSERT_NOW(a_angle_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata <= vad_pkg::ANGLE_180)
    `VAD_ASSERT_NOW(a_zero_len_angle, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == '0)
    `VAD_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, in_beat && i_s_axis_tlast, !o_s_axis_tready)

endmodule

// ===== verif/tb_vector_angle_degrees_unit.sv =====
`timescale 1ns / 1ps
module tb_vector_angle_degrees_unit;

    localparam int NUM_DIM   = vad_pkg::DEF_MAX_DIM;
    localparam int STALL_MAX = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // a_elem[15:0], b_elem[31:16]
    logic        i_s_axis_tlast = 1'b0; // last_elem
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;        // angle_deg[15:0]
    logic        o_m_axis_tuser;        // zero_length

    typedef struct packed {
        logic [15:0] angle;
        logic        zero_len;
    } t_angle_res;

    // running accumulators of the predicted block
    longint     dot_sum;
    longint     norm_a_sum;
    longint     norm_b_sum;
    int         pair_cnt;
    t_angle_res angle_q[$];
    int         err_cnt;
    int         idle_cnt;
    bit         in_flight;

    vector_angle_degrees_unit DUT (.*);

    always #4 i_clk = ~i_clk;

    // floor shift for signed values
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, bitv;
        r = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >>> 1) + bitv;
            end else begin
                r = r >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return r;
    endfunction

    function automatic int even_rshift(longint n);
        int s;
        s = 0;
        while ((n >> s) >= (64'sd1 <<< 31)) s += 2;
        return s;
    endfunction

    // cordic vectoring angle from the accumulated sums
    function automatic logic [15:0] vector_angle();
        longint na, nb, mag, x0, p, q2, x, y, z, nx, ny, q;
        int sa, sb;
        na = norm_a_sum;
        nb = norm_b_sum;
        sa = even_rshift(na);
        sb = even_rshift(nb);
        mag = dot_sum < 0 ? -dot_sum : dot_sum;
        na = na >> sa;
        nb = nb >> sb;
        x0 = mag >> ((sa + sb) / 2);
        p = na * nb;
        q2 = (x0 >= (64'sd1 <<< 31)) ? p + 1 : x0 * x0;
        y = (p > q2) ? int_sqrt(p - q2) : 0;
        x = x0;
        if (x == 0 && y == 0) return 16'd0;
        while ((x > y ? x : y) < (64'sd1 <<< 30)) begin
            x = x <<< 1;
            y = y <<< 1;
        end
        z = 0;
        for (int i = 0; i < vad_pkg::CORDIC_ITERS; i++) begin
            if (y >= 0) begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                z += longint'(vad_pkg::atan_tab(i[vad_pkg::ITER_W-1:0]));
            end else begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                z -= longint'(vad_pkg::atan_tab(i[vad_pkg::ITER_W-1:0]));
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        if (z > longint'(vad_pkg::Z_MAX)) z = longint'(vad_pkg::Z_MAX);
        q = (z + 128) >>> 8;
        if (dot_sum < 0) q = longint'(vad_pkg::ANGLE_180) - q;
        return q[15:0];
    endfunction

    // update prediction for one accepted pair
    task automatic predict_pair(logic [15:0] a_raw, logic [15:0] b_raw, logic last);
        longint a, b;
        t_angle_res r;
        a = longint'($signed(a_raw));
        b = longint'($signed(b_raw));
        if (pair_cnt < NUM_DIM) begin
            dot_sum += a * b;
            norm_a_sum += a * a;
            norm_b_sum += b * b;
            pair_cnt++;
        end
        if (last) begin
            if (norm_a_sum == 0 || norm_b_sum == 0) begin
                r.angle = 16'd0;
                r.zero_len = 1'b1;
            end else begin
                r.angle = vector_angle();
                r.zero_len = 1'b0;
            end
            angle_q.push_back(r);
            dot_sum = 0;
            norm_a_sum = 0;
            norm_b_sum = 0;
            pair_cnt = 0;
        end
    endtask

    // send one beat, with a random gap unless asked for none
    task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {b, a};
        i_s_axis_tlast <= last;
        in_flight = 1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_pair(a, b, last);
        in_flight = 0;
    endtask

    task automatic send_vector(int len, int mode);
        logic [15:0] a, b;
        bit burst;
        burst = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
            case (mode)
                0: begin a = 16'($urandom); b = 16'($urandom); end
                1: begin a = 16'($urandom_range(0, 511)) - 16'd256; b = 16'($urandom); end
                2: begin a = 16'($urandom); b = a; end
                3: begin a = 16'($urandom); b = -a; end
                default: begin a = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
                    b = $urandom_range(0, 1) ? 16'd0 : 16'($urandom); end
            endcase
            send_pair(a, b, k == len - 1, burst);
        end
    endtask

    // idle the source, dropping tvalid and tlast
    task automatic idle_source();
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast <= 1'b0;
        @(posedge i_clk);
    endtask

    // extremes, parallel, opposite and orthogonal vectors, zero vectors, overlong vectors
    task automatic test_directed();
        send_pair(16'h7fff, 16'h7fff, 1);
        send_pair(16'h8000, 16'h7fff, 1);
        send_pair(16'h8000, 16'h8000, 1);
        send_pair(16'h0100, 16'h0000, 1);
        send_pair(16'h0000, 16'h0000, 1);
        send_pair(16'h0100, 16'h0000, 0);
        send_pair(16'h0000, 16'h0100, 1);
        send_pair(16'h0001, 16'h0001, 0);
        send_pair(16'hffff, 16'h0001, 1);
        for (int k = 0; k < NUM_DIM + 3; k++)
            send_pair(16'h8000, (k >= NUM_DIM) ? 16'h1234 : 16'h8000, k == NUM_DIM + 2);
        send_pair(16'h0300, 16'h0400, 1);
        idle_source();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 1200) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_DIM + 1, NUM_DIM + 4)
                                              : $urandom_range(1, NUM_DIM);
            send_vector(len, $urandom_range(0, 4));
            sent += len;
            if ($urandom_range(0, 7) == 0) idle_source();
        end
        idle_source();
    endtask

    // receiver stalls
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_angle_res e;
            if (angle_q.size() == 0) begin
                $display("%0t: unexpected result angle=%0d zero=%0b", $time,
                         o_m_axis_tdata, o_m_axis_tuser);
                err_cnt++;
            end else begin
                e = angle_q.pop_front();
                if (o_m_axis_tdata !== e.angle) begin
                    $display("%0t: angle_deg expected %0d got %0d", $time,
                             e.angle, o_m_axis_tdata);
                    err_cnt++;
                end
                if (o_m_axis_tuser !== e.zero_len) begin
                    $display("%0t: zero_length expected %0b got %0b", $time,
                             e.zero_len, o_m_axis_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cnt <= 0;
        else if (i_rst_n && (in_flight || angle_q.size() != 0)) begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= STALL_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int waited;
        dot_sum = 0;
        norm_a_sum = 0;
        norm_b_sum = 0;
        pair_cnt = 0;
        err_cnt = 0;
        idle_cnt = 0;
        in_flight = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        waited = 0;
        while (angle_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (150) @(posedge i_clk);
        if (err_cnt == 0 && angle_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
